// ----- hdl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define STPA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked at every edge, reset included
`define STPA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ----- hdl/stpa_pkg.sv -----
`default_nettype none
package stpa_pkg;

   localparam int TABLE_SIZE_DEFAULT  = 500;
   localparam int SAMPLE_RATE_DEFAULT = 16000;

   localparam logic [15:0] AMPLITUDE_RESET = 16'd499;

   // fixed point for the tick difference mapping
   localparam int SLOPE_Q16  = 27282;
   localparam int OFFSET_Q16 = 4594074;
   // only this range of differences lands in [0, 1319) after scaling
   localparam int DIFF_MIN = -168;
   localparam int DIFF_MAX = 3000;

   localparam int QUEUE_DEPTH = 2;

   // angle arithmetic for the sine table
   localparam int              ANG_FRAC = 28;
   localparam longint unsigned PI_NUM   = 64'd314159;
   localparam longint unsigned PI_DEN   = 64'd100000;
   localparam longint unsigned ANG_ONE  = 64'd1 << ANG_FRAC;
   localparam longint unsigned PI_Q     = (PI_NUM << ANG_FRAC) / PI_DEN;
   localparam longint unsigned HALF_PI  = PI_Q / 2;

   typedef enum logic [1:0] {
      MODE_TICK     = 2'd0,
      MODE_SET_FREQ = 2'd1,
      MODE_SET_DIFF = 2'd2
   } mode_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // taylor series of sin on the first quadrant, 28 fraction bits
   function automatic longint unsigned quarter_sine(input longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      x2   = (x * x) >> ANG_FRAC;
      term = x;
      sum  = x;
      term = ((term * x2) >> ANG_FRAC) / 6;
      sum  = sum - term;
      term = ((term * x2) >> ANG_FRAC) / 20;
      sum  = sum + term;
      term = ((term * x2) >> ANG_FRAC) / 42;
      sum  = sum - term;
      term = ((term * x2) >> ANG_FRAC) / 72;
      sum  = sum + term;
      term = ((term * x2) >> ANG_FRAC) / 110;
      sum  = sum - term;
      term = ((term * x2) >> ANG_FRAC) / 156;
      sum  = sum + term;
      return sum;
   endfunction

   // (sin + 1) / 2 as unsigned q1.16, range 0..65536
   function automatic logic [16:0] sine_entry(input longint unsigned angle);
      longint unsigned a;
      longint unsigned s;
      longint unsigned mag;
      longint unsigned rounded;
      logic            neg;
      a   = angle;
      neg = 1'b0;
      if (a >= PI_Q) begin
         a   = a - PI_Q;
         neg = 1'b1;
      end
      if (a > PI_Q) begin
         a = PI_Q;
      end
      if (a > HALF_PI) begin
         a = PI_Q - a;
      end
      s = quarter_sine(a);
      if (s > ANG_ONE) begin
         s = ANG_ONE;
      end
      mag     = neg ? (ANG_ONE - s) : (ANG_ONE + s);
      mag     = mag >> 1;
      rounded = (mag + (64'd1 << (ANG_FRAC - 17))) >> (ANG_FRAC - 16);
      if (rounded > 64'd65536) begin
         rounded = 64'd65536;
      end
      return rounded[16:0];
   endfunction

endpackage
`default_nettype wire

// ----- hdl/stpa_queue.sv -----
`default_nettype none
module stpa_queue #(
   parameter int WIDTH = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic [WIDTH-1:0]            pop_data,
   output stpa_pkg::queue_status_type  status
);
   import stpa_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign do_push = push && (count_ff != CNT_W'(QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data         = entry_ff[rd_ptr_ff];
   assign status.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

endmodule
`default_nettype wire

// ----- hdl/stpa_front.sv -----
`default_nettype none
module stpa_front #(
   parameter int SAMPLE_RATE = stpa_pkg::SAMPLE_RATE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic [13:0]                         req_frequency,
   input  logic signed [31:0]                  req_tick_difference,
   input  stpa_pkg::queue_status_type          queue_status,
   output logic                                push,
   output logic [$clog2(SAMPLE_RATE)-1:0]      push_phase
);
   import stpa_pkg::*;

   localparam int PHASE_W = $clog2(SAMPLE_RATE);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PHASE_W-1:0] step_ff, step_in;
   logic [PHASE_W:0]   phase_sum;
   logic               accept;
   logic signed [12:0] diff_narrow;
   logic signed [28:0] scaled;
   logic [10:0]        diff_freq;
   logic               diff_in_range;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;

   assign phase_sum = {1'b0, phase_ff} + {1'b0, step_ff};

   // outside this window the scaled value is negative or at least 1319
   assign diff_in_range = (req_tick_difference >= 32'(DIFF_MIN)) &&
                          (req_tick_difference <= 32'(DIFF_MAX));
   assign diff_narrow   = req_tick_difference[12:0];
   assign scaled        = 29'(diff_narrow) * 29'sd27282 + 29'sd4594074;
   assign diff_freq     = diff_in_range ? scaled[26:16] : '0;

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      push     = 1'b0;
      if (accept) begin
         case (mode_type'(req_mode))
            MODE_TICK: begin
               push = 1'b1;
               if (phase_sum >= (PHASE_W+1)'(SAMPLE_RATE)) begin
                  phase_in = PHASE_W'(phase_sum - (PHASE_W+1)'(SAMPLE_RATE));
               end else begin
                  phase_in = phase_sum[PHASE_W-1:0];
               end
            end
            MODE_SET_FREQ: begin
               phase_in = '0;
               if (32'(req_frequency) > 32'(SAMPLE_RATE - 1)) begin
                  step_in = PHASE_W'(SAMPLE_RATE - 1);
               end else begin
                  step_in = PHASE_W'(req_frequency);
               end
            end
            MODE_SET_DIFF: begin
               phase_in = '0;
               if (32'(diff_freq) > 32'(SAMPLE_RATE - 1)) begin
                  step_in = PHASE_W'(SAMPLE_RATE - 1);
               end else begin
                  step_in = PHASE_W'(diff_freq);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   // sample uses the phase before this tick's advance
   assign push_phase = phase_ff;

endmodule
`default_nettype wire

// ----- hdl/stpa_back.sv -----
`default_nettype none
module stpa_back #(
   parameter int TABLE_SIZE  = stpa_pkg::TABLE_SIZE_DEFAULT,
   parameter int SAMPLE_RATE = stpa_pkg::SAMPLE_RATE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  stpa_pkg::queue_status_type       queue_status,
   input  logic [$clog2(SAMPLE_RATE)-1:0]   queue_phase,
   output logic                             pop,
   input  logic                             csr_we,
   input  logic [15:0]                      csr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [15:0]                      rsp_sample
);
   import stpa_pkg::*;

   localparam int PHASE_W = $clog2(SAMPLE_RATE);
   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int PROD_W  = $clog2(TABLE_SIZE * SAMPLE_RATE);
   localparam int RSHIFT  = PROD_W + PHASE_W;
   localparam int Q_W     = RSHIFT + IDX_W;
   // reciprocal exact for every product below TABLE_SIZE * SAMPLE_RATE
   localparam longint unsigned RECIP   = ((64'd1 << RSHIFT) + SAMPLE_RATE - 1) / SAMPLE_RATE;
   localparam longint unsigned ANG_DEN = PI_DEN * TABLE_SIZE;

   typedef logic [16:0] rom_array_type [TABLE_SIZE];

   function automatic rom_array_type build_rom();
      rom_array_type   r;
      longint unsigned ang;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         ang  = (64'd2 * PI_NUM * 64'(i) * ANG_ONE) / ANG_DEN;
         r[i] = sine_entry(ang);
      end
      return r;
   endfunction

   localparam rom_array_type SINE_ROM = build_rom();

   logic [15:0]       amplitude_ff;
   logic              advance;
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [Q_W-1:0]    quot_ff;
   logic [16:0]       rom_ff;
   logic [15:0]       sample_ff;
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  idx_raw;
   logic [IDX_W-1:0]  idx;
   logic [32:0]       scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff <= AMPLITUDE_RESET;
      end else if (csr_we) begin
         amplitude_ff <= csr_data;
      end
   end

   // the whole pipe moves together whenever the output slot frees up
   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && queue_status.not_empty;

   assign idx_raw = quot_ff[RSHIFT +: IDX_W];
   assign idx     = (idx_raw > IDX_W'(TABLE_SIZE - 1)) ? IDX_W'(TABLE_SIZE - 1) : idx_raw;
   assign scaled  = 33'(amplitude_ff) * 33'(rom_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= PROD_W'(queue_phase) * PROD_W'(TABLE_SIZE);
         quot_ff   <= Q_W'(prod_ff) * Q_W'(RECIP);
         rom_ff    <= SINE_ROM[idx];
         sample_ff <= scaled[31:16];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;

endmodule
`default_nettype wire

// ----- hdl/sine_tone_phase_accumulator.sv -----
`default_nettype none
// Sine tone generator built on a phase accumulator and a sine table ROM.
// Request channel (req_valid/req_ready): req_mode selects the transaction.
//   tick: returns one sample on the response channel, then advances the phase.
//   set frequency / set from tick difference: load the tone step, zero the
//   phase, no response. Unused mode code: ignored.
// Response channel (rsp_valid/rsp_ready): rsp_sample, 0..amplitude.
// csr_we/csr_data write the amplitude; only write while no tick is in flight.
// Throughput: one request per cycle while req_ready is high. The phase add
//   and wrap run in the front; the index divide, ROM read and amplitude
//   multiply form a four-stage back pipe fed from a two-entry queue.
// Path: queue, then product, quotient, ROM and sample registers in turn.
// Receiver stall: the back pipe freezes as a whole, the queue fills and then
//   req_ready drops; nothing is lost or repeated.
// Reset: phase and tone step clear, amplitude returns to 499, queue and pipe
//   empty. No clearing pass: the ROM is constant.
module sine_tone_phase_accumulator #(
   parameter int TABLE_SIZE  = stpa_pkg::TABLE_SIZE_DEFAULT,
   parameter int SAMPLE_RATE = stpa_pkg::SAMPLE_RATE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [13:0]        req_frequency,
   input  logic signed [31:0] req_tick_difference,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_sample,
   input  logic               csr_we,
   input  logic [15:0]        csr_data
);
   import stpa_pkg::*;

   localparam int PHASE_W = $clog2(SAMPLE_RATE);

   queue_status_type   queue_status;
   logic               push;
   logic               pop;
   logic [PHASE_W-1:0] push_phase;
   logic [PHASE_W-1:0] pop_phase;

   stpa_front #(
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_frequency       (req_frequency),
      .req_tick_difference (req_tick_difference),
      .queue_status        (queue_status),
      .push                (push),
      .push_phase          (push_phase)
   );

   stpa_queue #(
      .WIDTH (PHASE_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_phase),
      .pop       (pop),
      .pop_data  (pop_phase),
      .status    (queue_status)
   );

   stpa_back #(
      .TABLE_SIZE  (TABLE_SIZE),
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .queue_phase  (pop_phase),
      .pop          (pop),
      .csr_we       (csr_we),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_sample   (rsp_sample)
   );

endmodule
`default_nettype wire

// ----- hdl/stpa_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module stpa_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input wire [15:0]        rsp_sample,
   input wire               csr_we,
   input wire [15:0]        csr_data
);
   import stpa_pkg::*;

   logic [15:0] amplitude_ff;

   // shadow of the amplitude register
   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff <= AMPLITUDE_RESET;
      end else if (csr_we) begin
         amplitude_ff <= csr_data;
      end
   end

   `STPA_ASSERT(rsp_valid_holds, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")
   `STPA_ASSERT(rsp_sample_holds, rsp_valid && !rsp_ready |=> $stable(rsp_sample), "sample moved")
   `STPA_ASSERT_ALWAYS(no_rsp_after_reset, reset |=> !rsp_valid, "response out of reset")
   `STPA_ASSERT(sample_in_range, rsp_valid |-> rsp_sample <= amplitude_ff, "sample over amplitude")

endmodule

bind sine_tone_phase_accumulator stpa_checker u_checker (.*);
`default_nettype wire
